>>> src/gls_pkg.sv
package gls_pkg;

   localparam int unsigned COORD_W    = 6;
   localparam int unsigned CELL_W     = 5;
   localparam int unsigned COLOR_W    = 4;
   localparam int unsigned ACC_W      = 7;
   localparam int unsigned CNT_W      = 6;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 6;

   localparam int unsigned DEF_MAX_GRID  = 32;
   localparam int unsigned MAX_CELLS     = 63;
   localparam logic [COORD_W-1:0] GRID_SIZE_RESET = 6'd32;
   localparam logic [COLOR_W-1:0] PEN_COLOR_RESET = 4'd15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_SIZE = 1'b0,
      CSR_PEN_COLOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } gls_req_type;

   typedef struct packed {
      logic [CELL_W-1:0]  cell_x;
      logic [CELL_W-1:0]  cell_y;
      logic [COLOR_W-1:0] cell_color;
      logic               last_cell;
   } gls_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } gls_cmd_type;

   typedef struct packed {
      logic start_ok;
      logic last;
   } gls_status_type;

endpackage

>>> src/grid_line_stepper_top.sv
// Line stepper for a square pixel grid. A line command (start and end cell) is taken
// when start is high and busy is low. In the next cycle the start cell is checked; then
// the 4-connected cells of the line, start included and end excluded, come out one per
// cycle on rsp while rsp_valid is high, the final one with last_cell set. At most 63
// cells are plotted per command, one walk step of the datapath per cycle. The receiver
// cannot stall: every cell must be taken in the cycle it is shown. Registers grid_size
// and pen_color are written through the csr port, which is always ready; the user
// must write them only between commands, as the block itself does not enforce it.
module grid_line_stepper_top import gls_pkg::*; #(
   parameter int unsigned MAX_GRID = DEF_MAX_GRID
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  gls_req_type           req,
   output logic                  rsp_valid,
   output gls_rsp_type           rsp,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [COORD_W-1:0] grid_size_ff;
   logic [COLOR_W-1:0] pen_color_ff;
   gls_cmd_type        cmd;
   gls_status_type     status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RESET;
         pen_color_ff <= PEN_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_SIZE: grid_size_ff <= csr_data[COORD_W-1:0];
            CSR_PEN_COLOR: pen_color_ff <= csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   gls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   gls_datapath #(
      .MAX_GRID (MAX_GRID)
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .req       (req),
      .grid_size (grid_size_ff),
      .pen_color (pen_color_ff),
      .status    (status),
      .rsp       (rsp)
   );

   // a transaction always starts a busy period
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("command taken but block not busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("cell shown while idle");

   // cells of one line come out back to back and end on the marked one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last_cell |=> rsp_valid)
      else $error("gap inside a line");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last_cell |=> !rsp_valid && !busy)
      else $error("cells after the last one");

endmodule

>>> src/gls_ctrl.sv
module gls_ctrl import gls_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           rsp_valid,
   output gls_cmd_type    cmd,
   input  gls_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CHECK = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.start_ok ? ST_WALK : ST_IDLE;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_WALK);

endmodule

>>> src/gls_datapath.sv
module gls_datapath import gls_pkg::*; #(
   parameter int unsigned MAX_GRID = DEF_MAX_GRID
) (
   input  logic                clock,
   input  gls_cmd_type         cmd,
   input  gls_req_type         req,
   input  logic [COORD_W-1:0]  grid_size,
   input  logic [COLOR_W-1:0]  pen_color,
   output gls_status_type      status,
   output gls_rsp_type         rsp
);

   logic [COORD_W-1:0] x_ff, y_ff, ex_ff, ey_ff, dx_ff, dy_ff, g_ff;
   logic [COORD_W-1:0] x_in, y_in;
   logic               xneg_ff, yneg_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [COLOR_W-1:0] color_ff;

   logic               ld_xneg, ld_yneg;
   logic [COORD_W-1:0] ld_dx, ld_dy, usable_g;
   logic               brk, cont;

   assign usable_g = (grid_size > COORD_W'(MAX_GRID)) ? COORD_W'(MAX_GRID) : grid_size;
   assign ld_xneg  = req.end_x < req.start_x;
   assign ld_yneg  = req.end_y < req.start_y;
   assign ld_dx    = ld_xneg ? (req.start_x - req.end_x) : (req.end_x - req.start_x);
   assign ld_dy    = ld_yneg ? (req.start_y - req.end_y) : (req.end_y - req.start_y);

   // one walk step from the current cell
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      brk  = 1'b0;
      if (acc_ff >= {1'b0, dx_ff}) begin
         acc_in = acc_ff - {1'b0, dx_ff};
         if (yneg_ff) begin
            brk  = (y_ff == '0);
            y_in = y_ff - 1'b1;
         end else if (dy_ff != '0) begin
            y_in = y_ff + 1'b1;
         end
      end else begin
         acc_in = acc_ff + {1'b0, dy_ff};
         if (xneg_ff) begin
            brk  = (x_ff == '0);
            x_in = x_ff - 1'b1;
         end else if (dx_ff != '0) begin
            x_in = x_ff + 1'b1;
         end
      end
      cont = !brk && ((x_in != ex_ff) || (y_in != ey_ff)) && (x_in < g_ff) && (y_in < g_ff)
             && (cnt_ff != CNT_W'(MAX_CELLS - 1));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= req.start_x;
         y_ff     <= req.start_y;
         ex_ff    <= req.end_x;
         ey_ff    <= req.end_y;
         dx_ff    <= ld_dx;
         dy_ff    <= ld_dy;
         xneg_ff  <= ld_xneg;
         yneg_ff  <= ld_yneg;
         acc_ff   <= ACC_W'(ld_dx >> 1);
         cnt_ff   <= '0;
         g_ff     <= usable_g;
         color_ff <= pen_color;
      end else if (cmd.step) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.start_ok = ((x_ff != ex_ff) || (y_ff != ey_ff)) && (x_ff < g_ff) && (y_ff < g_ff);
   assign status.last     = !cont;

   assign rsp.cell_x     = x_ff[CELL_W-1:0];
   assign rsp.cell_y     = y_ff[CELL_W-1:0];
   assign rsp.cell_color = color_ff;
   assign rsp.last_cell  = !cont;

endmodule
